FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the morphology filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define GM3_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the usual clk_i / rst_ni pair of the enclosing module.
`define GM3_ASSERT_DFLT(label, prop, msg) \
  `GM3_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/gm3_pkg.sv
// ----------------------------------------------------------------------------
// gm3_pkg
// Types, constants and helper functions of the 3x3 grayscale morphology filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gm3_pkg;

  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  // Rows run up to frame height plus one while the last outputs drain.
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT + 2);

  localparam int unsigned RESET_DIM  = 512;
  localparam int unsigned EFF_RESET_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
  localparam int unsigned EFF_RESET_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  localparam logic [PIX_W-1:0] PAD_MAX_MODE = 8'd0;
  localparam logic [PIX_W-1:0] PAD_MIN_MODE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_index_e;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [2*PIX_W-1:0] line_word_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_last;
  } out_beat_t;

  function automatic pix_t pad_value(logic mode);
    return (mode == MODE_MIN) ? PAD_MIN_MODE : PAD_MAX_MODE;
  endfunction

  // Maximum in max mode, minimum in min mode.
  function automatic pix_t combine(logic mode, pix_t acc, pix_t v);
    pix_t res;
    if (mode == MODE_MIN) begin
      res = (v < acc) ? v : acc;
    end else begin
      res = (v > acc) ? v : acc;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gray_morphology_3x3_top.sv
// ----------------------------------------------------------------------------
// gray_morphology_3x3_top
// Streaming 3x3 grayscale maximum / minimum filter over raster-order pixels.
// ----------------------------------------------------------------------------
// A result beat is registered first in the work stage and then in the output register.
// Throughput: one input beat per cycle (one RAM read, one write) unless a held result stalls.
// Each output lags one row and one column, so frame_width + 1 drain beats flush a frame.
// Reset: asynchronous, active low; counters and flags clear at once, no clearing pass.
// Line store words are masked by the row position, so their contents need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_morphology_3x3_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input pixel stream
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire gm3_pkg::in_beat_t             in_data_i,
  // Output pixel stream
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output gm3_pkg::out_beat_t                 out_data_o,
  // Configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gm3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [gm3_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Work stage: the beat whose line store word is being read this cycle.
  typedef struct packed {
    logic                       emit;
    logic                       last;
    logic                       x_zero;
    logic                       row_ge1;
    logic                       row_ge2;
    logic [gm3_pkg::ADDR_W-1:0] addr;
    gm3_pkg::pix_t              col2;
  } stage_t;

  // Configuration registers hold the effective (clamped) dimensions.
  logic                      mode_q;
  logic [gm3_pkg::DIM_W-1:0] eff_w_q;
  logic [gm3_pkg::DIM_W-1:0] eff_h_q;

  // Input position counters, advanced when a beat is accepted.
  logic [gm3_pkg::ADDR_W-1:0] in_col_q, in_col_d;
  logic [gm3_pkg::ROW_W-1:0]  in_row_q, in_row_d;

  logic   s1_valid_q;
  stage_t s1_q, s1_d;
  logic   s1_done;
  logic   in_accept;

  // Bypass of a word written in the same cycle as it is read.
  logic                byp_q;
  gm3_pkg::line_word_t byp_word_q;
  gm3_pkg::line_word_t ram_rdata;
  gm3_pkg::line_word_t rd_word;
  gm3_pkg::line_word_t wr_word;

  gm3_pkg::pix_t win_q [6];
  gm3_pkg::pix_t col0, col1, pad_s1, acc;
  gm3_pkg::pix_t vals [9];

  logic               out_valid_q;
  gm3_pkg::out_beat_t out_q;

  logic [gm3_pkg::ADDR_W:0] col_next;
  logic                     col_wrap;
  logic                     row_ge_h;

  // Clamp a written dimension: zero acts as one, large values as the maximum.
  function automatic logic [gm3_pkg::DIM_W-1:0] clamp_dim(logic [gm3_pkg::DIM_W-1:0] v,
                                                          int unsigned            max_v);
    logic [gm3_pkg::DIM_W-1:0] res;
    if (v == '0) begin
      res = gm3_pkg::DIM_W'(1);
    end else if (32'(v) > max_v) begin
      res = gm3_pkg::DIM_W'(max_v);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control. The work stage retires unless it carries a result and the
  // output register is full and stalled; a new beat enters whenever it retires.
  // ---------------------------------------------------------------------------
  assign s1_done    = s1_valid_q && (!s1_q.emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_done;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Accept side: position bookkeeping, emit and frame-end decisions are all
  // made here, so the next beat already sees the restarted counters.
  // ---------------------------------------------------------------------------
  always_comb begin
    col_next = {1'b0, in_col_q} + (gm3_pkg::ADDR_W + 1)'(1);
    col_wrap = 32'(col_next) >= 32'(eff_w_q);
    row_ge_h = 32'(in_row_q) >= 32'(eff_h_q);

    s1_d.x_zero  = (in_col_q == '0);
    s1_d.row_ge1 = (in_row_q != '0);
    s1_d.row_ge2 = (32'(in_row_q) >= 32'd2);
    s1_d.emit    = s1_d.row_ge2 || (s1_d.row_ge1 && !s1_d.x_zero);
    // The final output (bottom-right position) comes with column zero of
    // the row just past the frame's last padding row.
    s1_d.last    = s1_d.x_zero && (32'(in_row_q) == 32'(eff_h_q) + 32'd1);
    s1_d.addr    = in_col_q;
    s1_d.col2    = (in_data_i.cmd == gm3_pkg::CMD_DRAIN || row_ge_h)
                   ? gm3_pkg::pad_value(mode_q) : in_data_i.pixel_in;

    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (s1_d.emit && s1_d.last) begin
      in_col_d = '0;
      in_row_d = '0;
    end else if (col_wrap) begin
      in_col_d = '0;
      in_row_d = in_row_q + gm3_pkg::ROW_W'(1);
    end else begin
      in_col_d = col_next[gm3_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= gm3_pkg::MODE_MAX;
      eff_w_q  <= gm3_pkg::DIM_W'(gm3_pkg::EFF_RESET_W);
      eff_h_q  <= gm3_pkg::DIM_W'(gm3_pkg::EFF_RESET_H);
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (cfg_valid_i) begin
      // Any write to an existing register restarts the frame.
      unique case (gm3_pkg::cfg_index_e'(cfg_index_i))
        gm3_pkg::CFG_MODE: begin
          mode_q   <= cfg_data_i[0];
          in_col_q <= '0;
          in_row_q <= '0;
        end
        gm3_pkg::CFG_WIDTH: begin
          eff_w_q  <= clamp_dim(cfg_data_i, gm3_pkg::MAX_WIDTH);
          in_col_q <= '0;
          in_row_q <= '0;
        end
        gm3_pkg::CFG_HEIGHT: begin
          eff_h_q  <= clamp_dim(cfg_data_i, gm3_pkg::MAX_HEIGHT);
          in_col_q <= '0;
          in_row_q <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one word per column packs the row above (upper byte) and the
  // row two above (lower byte). Read on accept, written back on retire.
  // ---------------------------------------------------------------------------
  gm3_line_ram u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_done),
    .waddr_i (s1_q.addr),
    .wdata_i (wr_word),
    .re_i    (in_accept),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // With a one-pixel row the beat being retired writes the very column the
  // incoming beat reads, so its word is forwarded past the RAM.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_accept) begin
      byp_q <= s1_done && (s1_q.addr == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byp_word_q <= wr_word;
    end
  end

  assign rd_word = byp_q ? byp_word_q : ram_rdata;

  // ---------------------------------------------------------------------------
  // Work stage: build the new column, reduce the 3x3 window, shift the window.
  // Rows not yet written in this frame read as padding.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    pad_s1  = gm3_pkg::pad_value(mode_q);
    col1    = s1_q.row_ge1 ? rd_word[2*gm3_pkg::PIX_W-1:gm3_pkg::PIX_W] : pad_s1;
    col0    = s1_q.row_ge2 ? rd_word[gm3_pkg::PIX_W-1:0] : pad_s1;
    wr_word = {s1_q.col2, col1};

    for (int i = 0; i < 6; i++) begin
      vals[i] = win_q[i];
    end
    // At column zero the new column belongs to the next row and is left out.
    vals[6] = s1_q.x_zero ? pad_s1 : col0;
    vals[7] = s1_q.x_zero ? pad_s1 : col1;
    vals[8] = s1_q.x_zero ? pad_s1 : s1_q.col2;

    acc = pad_s1;
    for (int i = 0; i < 9; i++) begin
      acc = gm3_pkg::combine(mode_q, acc, vals[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done) begin
      win_q[3] <= col0;
      win_q[4] <= col1;
      win_q[5] <= s1_q.col2;
      if (s1_q.x_zero) begin
        win_q[0] <= pad_s1;
        win_q[1] <= pad_s1;
        win_q[2] <= pad_s1;
      end else begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result beat until the receiver takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_done && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && s1_q.emit) begin
      out_q.pixel_out  <= acc;
      out_q.frame_last <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/gm3_line_ram.sv
// ----------------------------------------------------------------------------
// gm3_line_ram
// Simple dual-port line store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gm3_line_ram (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [gm3_pkg::ADDR_W-1:0] waddr_i,
  input  wire gm3_pkg::line_word_t       wdata_i,
  input  wire logic                      re_i,
  input  wire logic [gm3_pkg::ADDR_W-1:0] raddr_i,
  output gm3_pkg::line_word_t            rdata_o
);

  gm3_pkg::line_word_t mem_q [gm3_pkg::MAX_WIDTH];
  gm3_pkg::line_word_t rdata_q;

  // A read at the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/gm3_checker.sv
// ----------------------------------------------------------------------------
// gm3_checker
// Port-level assertions for the 3x3 grayscale morphology filter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gm3_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_i,
  input wire logic               out_valid_i,
  input wire logic               out_stall_i,
  input wire gm3_pkg::out_beat_t out_data_i,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_i
);

  logic in_beat;
  logic out_held;

  assign in_beat  = in_valid_i && !in_stall_i;
  assign out_held = out_valid_i && out_stall_i;

  // The input side only stalls while a full output register is held back.
  `GM3_ASSERT_DFLT(a_stall_cause, in_stall_i |-> out_held, "stall without blocked output")

  // A fresh result follows an input beat that went through the work stage.
  `GM3_ASSERT_DFLT(a_out_source, $rose(out_valid_i) |-> $past(in_beat, 2), "orphan result")

  // Configuration writes are never refused.
  `GM3_ASSERT_DFLT(a_cfg_ready, cfg_valid_i |-> cfg_ready_i, "configuration write refused")

  // A stalled result beat stays and keeps its payload.
  `GM3_ASSERT_DFLT(a_out_hold, out_held |=> out_valid_i && $stable(out_data_i), "result changed")

endmodule

bind gray_morphology_3x3_top gm3_checker u_gm3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o)
);

`default_nettype wire

FILE: tb/tb_gray_morphology_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gray_morphology_3x3_top
// Self-checking bench for the streaming 3x3 grayscale max / min filter.
// Pixel and drain beats are streamed into the block, and a cycle-free model
// of the line stores and window predicts every result beat. Frame sizes,
// mode, border cases and flow control are varied from phase to phase.
// ----------------------------------------------------------------------------

module tb_gray_morphology_3x3_top;

  // Bench timing and run control.
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned SETTLE_BOUND  = 200000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_BEATS  = 100;

  // A register index past the end of the register list; writes to it are ignored.
  localparam logic [gm3_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  // Clock, reset and block ports.
  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  gm3_pkg::in_beat_t              in_data_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  gm3_pkg::out_beat_t             out_data_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [gm3_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [gm3_pkg::CFG_DATA_W-1:0] cfg_data_i;

  always #6 clk_i = ~clk_i;

  gray_morphology_3x3_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Filter model. It mirrors the register settings and holds its own copy of
  // the two line stores, the six-entry window and the raster counters.
  // --------------------------------------------------------------------------
  logic          cur_mode;
  logic [9:0]    cur_width;
  logic [9:0]    cur_height;
  gm3_pkg::pix_t row_above [gm3_pkg::MAX_WIDTH];   // row just before the current input row
  gm3_pkg::pix_t row_two_up [gm3_pkg::MAX_WIDTH];  // row two above the current input row
  gm3_pkg::pix_t win_px [6];                       // two previous columns, top to bottom
  int unsigned   col_pos;
  int unsigned   row_pos;
  int unsigned   emitted;

  // Queues between the stimulus, the driver and the checker.
  gm3_pkg::in_beat_t  pending_beats[$];
  gm3_pkg::out_beat_t filtered_q[$];

  // Flow-control knobs; the stimulus process changes them per phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_go;
  logic        out_hold;
  logic        in_offer;

  // Bookkeeping.
  int unsigned mismatches;
  int unsigned beats_queued;
  int unsigned beats_taken;
  int unsigned results_seen;
  int unsigned frame_ends;
  int unsigned reg_writes;
  int unsigned cycle_count;

  gm3_pkg::out_beat_t predicted;
  gm3_pkg::out_beat_t observed;
  gm3_pkg::out_beat_t wanted;

  function automatic gm3_pkg::pix_t pad_of(logic m);
    return (m == gm3_pkg::MODE_MIN) ? gm3_pkg::PAD_MIN_MODE : gm3_pkg::PAD_MAX_MODE;
  endfunction

  function automatic gm3_pkg::pix_t merge(logic m, gm3_pkg::pix_t acc, gm3_pkg::pix_t v);
    if (m == gm3_pkg::MODE_MIN) begin
      return (v < acc) ? v : acc;
    end
    return (v > acc) ? v : acc;
  endfunction

  // Zero behaves as one, and anything past the maximum behaves as the maximum.
  function automatic int unsigned eff_dim(logic [9:0] v, int unsigned limit);
    if (v == 0) begin
      return 1;
    end
    if (v > limit) begin
      return limit;
    end
    return v;
  endfunction

  function automatic void restart_frame();
    gm3_pkg::pix_t p;
    p = pad_of(cur_mode);
    for (int i = 0; i < gm3_pkg::MAX_WIDTH; i++) begin
      row_above[i]  = p;
      row_two_up[i] = p;
    end
    for (int i = 0; i < 6; i++) begin
      win_px[i] = p;
    end
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
  endfunction

  // Every write to an existing register restarts the frame, even when the
  // value does not change.
  function automatic void apply_reg_write(logic [gm3_pkg::CFG_IDX_W-1:0] idx,
                                          logic [gm3_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      gm3_pkg::CFG_MODE: begin
        cur_mode = val[0];
      end
      gm3_pkg::CFG_WIDTH: begin
        cur_width = val;
      end
      gm3_pkg::CFG_HEIGHT: begin
        cur_height = val;
      end
      default: begin
        return;
      end
    endcase
    restart_frame();
  endfunction

  // One accepted beat. Returns 1 when the beat completes an output position.
  function automatic bit morph_step(input gm3_pkg::in_beat_t b,
                                    output gm3_pkg::out_beat_t r);
    int unsigned   w;
    int unsigned   h;
    int unsigned   x;
    gm3_pkg::pix_t pad;
    gm3_pkg::pix_t acc;
    gm3_pkg::pix_t col [3];
    bit            emit;
    bit            last;
    w   = eff_dim(cur_width, gm3_pkg::MAX_WIDTH);
    h   = eff_dim(cur_height, gm3_pkg::MAX_HEIGHT);
    pad = pad_of(cur_mode);
    x   = (col_pos >= w) ? 0 : col_pos;
    r   = '0;

    // Drain beats and anything below the last row supply border padding.
    col[2] = (b.cmd == gm3_pkg::CMD_DRAIN || row_pos >= h) ? pad : b.pixel_in;
    col[0] = row_two_up[x];
    col[1] = row_above[x];
    row_two_up[x] = col[1];
    row_above[x]  = col[2];

    emit = (row_pos >= 2) || (row_pos == 1 && x >= 1);
    acc  = pad;
    if (emit) begin
      for (int i = 0; i < 6; i++) begin
        acc = merge(cur_mode, acc, win_px[i]);
      end
      // At column zero the new column belongs to the next row's window.
      if (x != 0) begin
        for (int i = 0; i < 3; i++) begin
          acc = merge(cur_mode, acc, col[i]);
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      win_px[i]     = (x == 0) ? pad : win_px[3 + i];
      win_px[3 + i] = col[i];
    end

    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end

    if (emit) begin
      last         = (emitted + 1) >= w * h;
      r.pixel_out  = acc;
      r.frame_last = last;
      emitted++;
      if (last) begin
        restart_frame();
      end
    end
    return emit;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting.
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Input driver. A beat stays on the bus until it is taken; the checker
  // process clears in_offer at the edge where the handshake completes.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_offer) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_beats[0];
        in_offer = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stalls plus the long hold-off when requested.
  always @(negedge clk_i) begin
    out_stall_i <= out_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // The long hold-off runs in its own process and counts its cycles there.
  initial begin
    out_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge; the input side
  // feeds the model and the output side is checked against its predictions.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        in_offer = 1'b0;
        if (morph_step(in_data_i, predicted)) begin
          filtered_q.push_back(predicted);
        end
        void'(pending_beats.pop_front());
        beats_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        observed = out_data_o;
        results_seen++;
        if (observed.frame_last) begin
          frame_ends++;
        end
        if (filtered_q.size() == 0) begin
          flag_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                  results_seen));
        end else begin
          wanted = filtered_q.pop_front();
          if (observed.pixel_out !== wanted.pixel_out) begin
            flag_mismatch($sformatf("result %0d pixel_out: got %0d, expected %0d",
                                    results_seen, observed.pixel_out, wanted.pixel_out));
          end
          if (observed.frame_last !== wanted.frame_last) begin
            flag_mismatch($sformatf("result %0d frame_last: got %0b, expected %0b",
                                    results_seen, observed.frame_last,
                                    wanted.frame_last));
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("[gray_morphology_3x3_top] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  // Flat values are common in images, and the extremes stress max and min.
  function automatic gm3_pkg::pix_t rand_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return gm3_pkg::pix_t'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_beat(input logic cmd, input gm3_pkg::pix_t v);
    gm3_pkg::in_beat_t b;
    b.cmd      = cmd;
    b.pixel_in = v;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Pixel beats of a frame; a few may be swapped for drain beats, which the
  // block must treat as padding pixels.
  task automatic queue_pixels(input int unsigned n, input int unsigned drain_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < drain_pct) begin
        queue_beat(gm3_pkg::CMD_DRAIN, rand_pixel());
      end else begin
        queue_beat(gm3_pkg::CMD_PIXEL, rand_pixel());
      end
    end
  endtask

  // Flush beats after the last row. Some are sent as pixel beats; below the
  // frame they must count as padding just the same.
  task automatic queue_flush(input int unsigned n, input int unsigned stray_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < stray_pct) begin
        queue_beat(gm3_pkg::CMD_PIXEL, rand_pixel());
      end else begin
        queue_beat(gm3_pkg::CMD_DRAIN, rand_pixel());
      end
    end
  endtask

  // One full frame at the current effective size, plus width + 1 flush beats.
  task automatic queue_frame(input int unsigned drain_pct, input int unsigned stray_pct);
    int unsigned w;
    int unsigned h;
    w = eff_dim(cur_width, gm3_pkg::MAX_WIDTH);
    h = eff_dim(cur_height, gm3_pkg::MAX_HEIGHT);
    queue_pixels(w * h, drain_pct);
    queue_flush(w + 1, stray_pct);
  endtask

  task automatic write_reg(input logic [gm3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gm3_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg_write(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic m, input logic [9:0] wv, input logic [9:0] hv);
    write_reg(gm3_pkg::CFG_MODE, gm3_pkg::CFG_DATA_W'(m));
    write_reg(gm3_pkg::CFG_WIDTH, wv);
    write_reg(gm3_pkg::CFG_HEIGHT, hv);
    @(posedge clk_i);
  endtask

  // Waits until every queued beat is taken and every predicted result has
  // come back, then lets the pipeline empty out behind beats that had no result.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while ((pending_beats.size() != 0 || in_offer || filtered_q.size() != 0) &&
           waited < SETTLE_BOUND) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Four flow-control patterns, rotated across phases.
  task automatic set_idling(input int unsigned pattern);
    case (pattern % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 47;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 47;
      end
      default: begin
        send_idle_pct  = 10;
        recv_stall_pct = 10;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned w;
    int unsigned h;
    int unsigned random_start;
    logic        m;
    logic [9:0]  wv;
    logic [9:0]  hv;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = gm3_pkg::CFG_MODE;
    cfg_data_i     = '0;
    in_offer       = 1'b0;
    hold_go        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    beats_queued   = 0;
    beats_taken    = 0;
    results_seen   = 0;
    frame_ends     = 0;
    reg_writes     = 0;
    cycle_count    = 0;

    // The model starts from the register reset values.
    cur_mode   = gm3_pkg::MODE_MAX;
    cur_width  = 10'(gm3_pkg::RESET_DIM);
    cur_height = 10'(gm3_pkg::RESET_DIM);
    restart_frame();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a 3x3 frame in the reset mode (max, zero border) with bright
    // opposite corners, so every window sees the right mix of 0 and 255.
    write_reg(gm3_pkg::CFG_WIDTH, 10'd3);
    write_reg(gm3_pkg::CFG_HEIGHT, 10'd3);
    @(posedge clk_i);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd255);
    for (int i = 0; i < 7; i++) begin
      queue_beat(gm3_pkg::CMD_PIXEL, 8'd0);
    end
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd255);
    queue_flush(4, 0);
    settle();

    // Width and height of zero act as one: two back-to-back 1x1 frames in min
    // mode, the second relying on the automatic restart after frame end.
    configure(gm3_pkg::MODE_MIN, 10'd0, 10'd0);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd0);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd255);
    queue_beat(gm3_pkg::CMD_DRAIN, 8'd0);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd128);
    queue_beat(gm3_pkg::CMD_DRAIN, 8'd255);
    queue_beat(gm3_pkg::CMD_DRAIN, 8'd0);
    settle();

    // A drain beat inside the frame is a padding pixel, and a pixel beat
    // below the frame is padding too.
    configure(gm3_pkg::MODE_MIN, 10'd2, 10'd2);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd17);
    queue_beat(gm3_pkg::CMD_DRAIN, 8'd0);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd200);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd255);
    queue_beat(gm3_pkg::CMD_PIXEL, 8'd0);
    queue_beat(gm3_pkg::CMD_DRAIN, 8'd0);
    queue_beat(gm3_pkg::CMD_DRAIN, 8'd255);
    settle();

    // A write to an index past the register list must leave a frame in
    // progress untouched: half a frame, the stray write, then the rest.
    configure(gm3_pkg::MODE_MAX, 10'd4, 10'd3);
    queue_pixels(6, 0);
    settle();
    write_reg(CFG_NONE, gm3_pkg::CFG_DATA_W'($urandom_range(1023)));
    @(posedge clk_i);
    queue_pixels(6, 0);
    queue_flush(5, 0);
    settle();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering beats, so the block fills up and stalls its input.
    set_idling(0);
    configure(logic'($urandom_range(1)), 10'd12, 10'd4);
    queue_frame(5, 30);
    hold_go = 1'b1;
    settle();

    // Size extremes: an out-of-range width must act as the maximum width, so
    // the second row starts giving results right after the clamped first row;
    // the frame is cut off there and restarted by the next register write.
    // Then an out-of-range height with the narrowest row runs a full frame.
    set_idling(3);
    configure(gm3_pkg::MODE_MIN, 10'd1023, 10'd2);
    queue_pixels(gm3_pkg::MAX_WIDTH + 4, 2);
    settle();
    set_idling(1);
    configure(gm3_pkg::MODE_MAX, 10'd1, 10'd1023);
    queue_frame(2, 20);
    settle();

    // Random phases: mostly small frames with random content and settings,
    // a few flush beats swapped for pixels, and now and then a frame cut off
    // midway so that the next register write has to restart it.
    phase        = 0;
    random_start = beats_queued;
    while (beats_queued - random_start < RANDOM_BEATS) begin
      set_idling(phase);
      m  = logic'($urandom_range(1));
      wv = 10'($urandom_range(1, 8));
      hv = 10'($urandom_range(1, 5));
      case ($urandom_range(11))
        0: wv = 10'd0;
        1: hv = 10'd0;
        2: begin
          wv = 10'($urandom_range(3, 20));
          hv = 10'($urandom_range(1, 2));
        end
        default: ;
      endcase
      configure(m, wv, hv);
      w = eff_dim(cur_width, gm3_pkg::MAX_WIDTH);
      h = eff_dim(cur_height, gm3_pkg::MAX_HEIGHT);
      repeat ($urandom_range(1, 2)) queue_frame(4, 25);
      if ($urandom_range(3) == 0 && w * h > 1) begin
        queue_pixels($urandom_range(1, w * h - 1), 4);
      end
      settle();
      phase++;
    end

    // Last phase has no idling at all before the final wait.
    set_idling(0);
    configure(logic'($urandom_range(1)), 10'd5, 10'd4);
    queue_frame(0, 0);
    settle();

    if (filtered_q.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", filtered_q.size()));
    end

    $display("Run: %0d beats in, %0d results checked, %0d frame ends, %0d register writes.",
             beats_taken, results_seen, frame_ends, reg_writes);
    $display("Both modes, sizes from 1x1 to the clamped limits, stray drains and held output.");
    if (mismatches == 0) begin
      $display("[gray_morphology_3x3_top] OK");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("[gray_morphology_3x3_top] ERROR");
    end
    $finish;
  end

endmodule
